// ===== hw/rtl/dsag_pkg.sv =====
// Shared types and constants of the strided DMA address generator.
package dsag_pkg;

    // Fixed field widths of the request and result channels.
    localparam int MAIN_W       = 24;
    localparam int LOCAL_ADDR_W = 13;
    localparam int LENGTH_W     = 32;
    localparam int MAIN_IN_W    = 32;
    localparam int LEN_FIELD_W  = 12;
    localparam int ROWS_W       = 8;
    localparam int ROW_LEN_W    = 13;
    localparam int SKIP_W       = 13;
    localparam int KIND_W       = 3;

    // Positions inside the packed length word.
    localparam int ROWS_LSB = 12;
    localparam int SKIP_LSB = 20;

    // Highest main address that a start may name.
    localparam logic [MAIN_W-1:0] MAIN_LIMIT = 24'h80_0000;

    // Byte lane swap applied to both output addresses.
    localparam logic [2:0] LANE_SWAP = 3'd3;

    // Rows are rounded up to whole 8-byte words.
    localparam logic [2:0] WORD_MASK = 3'd7;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_STARTED  = 3'd0,
        KIND_BAD_MAIN = 3'd1,
        KIND_SEGMENT  = 3'd2,
        KIND_BYTE     = 3'd3,
        KIND_IDLE     = 3'd4
    } kind_t;

    // Classified requests as they travel from front to back.
    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_BAD_MAIN = 2'd1,
        CMD_SEGMENT  = 2'd2,
        CMD_ADVANCE  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                    cmd;
        logic                    to_main;
        logic [MAIN_W-1:0]       main_start;
        logic [LOCAL_ADDR_W-1:0] local_start;
        logic [ROW_LEN_W-1:0]    row_length;
        logic [SKIP_W-1:0]       row_skip;
        logic [ROWS_W-1:0]       rows_left;
    } queue_entry_t;

endpackage

// ===== hw/rtl/dsag_front.sv =====
// Front part: classifies each request and decodes the start parameters.
module dsag_front #(
    parameter int SEGMENT_SIZE = 4096
) (
    input  logic                             mode,
    input  logic                             to_main,
    input  logic [dsag_pkg::MAIN_IN_W-1:0]    main_address,
    input  logic [dsag_pkg::LOCAL_ADDR_W-1:0] local_address,
    input  logic [dsag_pkg::LENGTH_W-1:0]     length_word,
    output dsag_pkg::queue_entry_t           entry
);
    import dsag_pkg::*;

    // Width that holds a length plus an offset inside a segment.
    localparam int SUM_W     = $clog2(SEGMENT_SIZE + (1 << LEN_FIELD_W) + 1) + 1;
    // Number of whole segments the local address range can span.
    localparam int SEG_COUNT = (1 << LOCAL_ADDR_W) / SEGMENT_SIZE;

    logic [MAIN_W-1:0]      main_masked;
    logic [LEN_FIELD_W-1:0] len_field;
    logic [SUM_W-1:0]       seg_offset;
    logic [SUM_W-1:0]       seg_end;
    logic                   bad_main;
    logic                   seg_over;
    logic [ROW_LEN_W-1:0]   row_length;

    assign main_masked = main_address[MAIN_W-1:0];
    assign len_field   = length_word[LEN_FIELD_W-1:0];
    assign bad_main    = main_masked > MAIN_LIMIT;

    // Offset of the local address inside its segment, by independent compares.
    always_comb begin
        seg_offset = SUM_W'(local_address);
        for (int k = 1; k <= SEG_COUNT; k++) begin
            if (SUM_W'(local_address) >= SUM_W'(k * SEGMENT_SIZE)) begin
                seg_offset = SUM_W'(local_address) - SUM_W'(k * SEGMENT_SIZE);
            end
        end
    end

    // A row may not run past the end of its segment.
    assign seg_end  = SUM_W'(len_field) + SUM_W'(1) + seg_offset;
    assign seg_over = seg_end > SUM_W'(SEGMENT_SIZE);

    // Row length rounded up to whole words.
    assign row_length = (ROW_LEN_W'(len_field) | ROW_LEN_W'(WORD_MASK)) + ROW_LEN_W'(1);

    // Build the queue entry.
    always_comb begin
        entry.to_main     = to_main;
        entry.main_start  = {main_masked[MAIN_W-1:3], 3'b000};
        entry.local_start = local_address;
        entry.row_length  = row_length;
        entry.row_skip    = SKIP_W'(length_word[SKIP_LSB +: LEN_FIELD_W]) + row_length;
        entry.rows_left   = length_word[ROWS_LSB +: ROWS_W];
        priority if (mode) begin
            entry.cmd = CMD_ADVANCE;
        end else if (bad_main) begin
            entry.cmd = CMD_BAD_MAIN;
        end else if (seg_over) begin
            entry.cmd = CMD_SEGMENT;
        end else begin
            entry.cmd = CMD_START;
        end
    end

endmodule

// ===== hw/rtl/dsag_queue.sv =====
// Short request queue between the front and back parts.
module dsag_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  dsag_pkg::queue_entry_t push_entry,
    output logic                   ready,
    input  logic                   pop,
    output logic                   valid,
    output dsag_pkg::queue_entry_t head
);
    import dsag_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_entry_t     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hw/rtl/dsag_back.sv =====
// Back part: copy state, running address adders and the result register.
module dsag_back #(
    parameter int LOCAL_SPAN = 8192
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  dsag_pkg::queue_entry_t            q_entry,
    output logic                              q_pop,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [dsag_pkg::KIND_W-1:0]       m_kind,
    output logic                              m_to_main_out,
    output logic [dsag_pkg::LOCAL_ADDR_W-1:0] m_local_byte_address,
    output logic [dsag_pkg::MAIN_W-1:0]       m_main_byte_address,
    output logic                              m_last
);
    import dsag_pkg::*;

    // Local address width, and a width wide enough for the output too.
    localparam int LAW = $clog2(LOCAL_SPAN);
    localparam int OW  = (LAW > LOCAL_ADDR_W) ? LAW : LOCAL_ADDR_W;

    // Copy state.
    logic                   active_reg, active_next;
    logic                   dir_reg, dir_next;
    logic [ROW_LEN_W-1:0]   row_length_reg, row_length_next;
    logic [SKIP_W-1:0]      row_skip_reg, row_skip_next;
    logic [ROWS_W-1:0]      rows_left_reg, rows_left_next;
    logic [LEN_FIELD_W-1:0] byte_index_reg, byte_index_next;
    logic [LAW-1:0]         local_row_reg, local_row_next;
    logic [MAIN_W-1:0]      main_row_reg, main_row_next;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg, out_kind_next;
    logic                    out_dir_reg, out_dir_next;
    logic [LOCAL_ADDR_W-1:0] out_local_reg, out_local_next;
    logic [MAIN_W-1:0]       out_main_reg, out_main_next;
    logic                    out_last_reg, out_last_next;

    // Datapath terms.
    logic [LAW-1:0]       local_byte;
    logic [LAW-1:0]       local_start;
    logic [OW-1:0]        local_out_wide;
    logic [MAIN_W-1:0]    main_byte;
    logic [ROW_LEN_W-1:0] index_inc;
    logic                 row_done;

    // Wrap a local address sum that stays below twice the span.
    function automatic logic [LAW-1:0] local_wrap(input logic [LAW:0] a);
        logic [LAW:0] w;
        w = (a >= (LAW + 1)'(LOCAL_SPAN)) ? a - (LAW + 1)'(LOCAL_SPAN) : a;
        return w[LAW-1:0];
    endfunction

    // A request leaves the queue when the result register is free or drains.
    assign q_pop = q_valid && (!out_valid_reg || m_ready);

    // Running address adders.
    assign local_byte  = local_wrap((LAW + 1)'(local_row_reg) + (LAW + 1)'(byte_index_reg));
    assign local_out_wide = OW'(local_byte) ^ OW'(LANE_SWAP);
    assign main_byte   = (main_row_reg + MAIN_W'(byte_index_reg)) ^ MAIN_W'(LANE_SWAP);
    assign index_inc   = ROW_LEN_W'(byte_index_reg) + ROW_LEN_W'(1);
    assign row_done    = index_inc >= row_length_reg;
    assign local_start = local_wrap((LAW + 1)'(q_entry.local_start)) & ~LAW'(WORD_MASK);

    // Next state and next result.
    always_comb begin
        active_next     = active_reg;
        dir_next        = dir_reg;
        row_length_next = row_length_reg;
        row_skip_next   = row_skip_reg;
        rows_left_next  = rows_left_reg;
        byte_index_next = byte_index_reg;
        local_row_next  = local_row_reg;
        main_row_next   = main_row_reg;

        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_dir_next   = out_dir_reg;
        out_local_next = out_local_reg;
        out_main_next  = out_main_reg;
        out_last_next  = out_last_reg;

        if (q_pop) begin
            out_valid_next = 1'b1;
            out_dir_next   = 1'b0;
            out_local_next = '0;
            out_main_next  = '0;
            out_last_next  = 1'b0;
            unique case (q_entry.cmd)
                CMD_START: begin
                    out_kind_next   = KIND_STARTED;
                    active_next     = 1'b1;
                    dir_next        = q_entry.to_main;
                    row_length_next = q_entry.row_length;
                    row_skip_next   = q_entry.row_skip;
                    rows_left_next  = q_entry.rows_left;
                    byte_index_next = '0;
                    local_row_next  = local_start;
                    main_row_next   = q_entry.main_start;
                end
                CMD_BAD_MAIN: begin
                    out_kind_next = KIND_BAD_MAIN;
                end
                CMD_SEGMENT: begin
                    out_kind_next = KIND_SEGMENT;
                end
                CMD_ADVANCE: begin
                    if (!active_reg) begin
                        out_kind_next = KIND_IDLE;
                    end else begin
                        out_kind_next  = KIND_BYTE;
                        out_dir_next   = dir_reg;
                        out_local_next = local_out_wide[LOCAL_ADDR_W-1:0];
                        out_main_next  = main_byte;
                        if (row_done) begin
                            byte_index_next = '0;
                            local_row_next  = local_wrap((LAW + 1)'(local_row_reg)
                                                         + (LAW + 1)'(row_length_reg));
                            main_row_next   = main_row_reg + MAIN_W'(row_skip_reg);
                            if (rows_left_reg == '0) begin
                                out_last_next = 1'b1;
                                active_next   = 1'b0;
                            end else begin
                                rows_left_next = rows_left_reg - ROWS_W'(1);
                            end
                        end else begin
                            byte_index_next = index_inc[LEN_FIELD_W-1:0];
                        end
                    end
                end
                default: begin
                    out_kind_next = KIND_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            dir_reg        <= 1'b0;
            row_length_reg <= '0;
            row_skip_reg   <= '0;
            rows_left_reg  <= '0;
            byte_index_reg <= '0;
            local_row_reg  <= '0;
            main_row_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            active_reg     <= active_next;
            dir_reg        <= dir_next;
            row_length_reg <= row_length_next;
            row_skip_reg   <= row_skip_next;
            rows_left_reg  <= rows_left_next;
            byte_index_reg <= byte_index_next;
            local_row_reg  <= local_row_next;
            main_row_reg   <= main_row_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_dir_reg   <= out_dir_next;
        out_local_reg <= out_local_next;
        out_main_reg  <= out_main_next;
        out_last_reg  <= out_last_next;
    end

    assign m_valid              = out_valid_reg;
    assign m_kind               = out_kind_reg;
    assign m_to_main_out        = out_dir_reg;
    assign m_local_byte_address = out_local_reg;
    assign m_main_byte_address  = out_main_reg;
    assign m_last               = out_last_reg;

endmodule

// ===== hw/rtl/strided_dma_address_generator_unit.sv =====
// Strided DMA address generator: a 2D byte address walker between local and main memory.
//
// Requests arrive on the s_ channel (valid/ready). A request with s_mode low
// starts a copy: it is checked for a main address above 0x800000 and for a
// row that passes its local segment, and otherwise loads the row length,
// row count, skip and both start addresses. A request with s_mode high
// advances one byte and yields the local and main byte addresses (XOR 3).
// Every request gives exactly one result on the m_ channel (valid/ready).
// An accepted request is written into the queue and, when nothing waits ahead
// of it, then into the result register that drives m_valid. Throughput is one
// request per cycle while the receiver keeps m_ready high.
// A two-entry queue separates the decode front from the back part, and the
// queue takes new requests while a result waits in the result register.
// When the receiver stalls, the queue fills and s_ready drops after two
// further requests. Reset (aresetn low, synchronous) empties the queue and
// the result register and leaves the engine idle with no copy running.
module strided_dma_address_generator_unit #(
    parameter int LOCAL_SPAN   = 8192,
    parameter int SEGMENT_SIZE = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_mode,
    input  logic                              s_to_main,
    input  logic [dsag_pkg::MAIN_IN_W-1:0]    s_main_address,
    input  logic [dsag_pkg::LOCAL_ADDR_W-1:0] s_local_address,
    input  logic [dsag_pkg::LENGTH_W-1:0]     s_length_word,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [dsag_pkg::KIND_W-1:0]       m_kind,
    output logic                              m_to_main_out,
    output logic [dsag_pkg::LOCAL_ADDR_W-1:0] m_local_byte_address,
    output logic [dsag_pkg::MAIN_W-1:0]       m_main_byte_address,
    output logic                              m_last
);
    import dsag_pkg::*;

    queue_entry_t front_entry;
    queue_entry_t head_entry;
    logic         head_valid;
    logic         head_pop;

    // Decode and classify the incoming request.
    dsag_front #(
        .SEGMENT_SIZE(SEGMENT_SIZE)
    ) u_front (
        .mode         (s_mode),
        .to_main      (s_to_main),
        .main_address (s_main_address),
        .local_address(s_local_address),
        .length_word  (s_length_word),
        .entry        (front_entry)
    );

    // Queue between front and back.
    dsag_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && s_ready),
        .push_entry(front_entry),
        .ready     (s_ready),
        .pop       (head_pop),
        .valid     (head_valid),
        .head      (head_entry)
    );

    // Copy state and result generation.
    dsag_back #(
        .LOCAL_SPAN(LOCAL_SPAN)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_valid             (head_valid),
        .q_entry             (head_entry),
        .q_pop               (head_pop),
        .m_ready             (m_ready),
        .m_valid             (m_valid),
        .m_kind              (m_kind),
        .m_to_main_out       (m_to_main_out),
        .m_local_byte_address(m_local_byte_address),
        .m_main_byte_address (m_main_byte_address),
        .m_last              (m_last)
    );

endmodule

// ===== tb/sv/strided_dma_address_generator_unit_tb.sv =====
// Self-checking testbench for the strided DMA address generator unit.
module strided_dma_address_generator_unit_tb;
    import dsag_pkg::*;

    localparam int LOCAL_SPAN     = 8192;
    localparam int SEGMENT_SIZE   = 4096;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 4;
    localparam int ITEM_COUNT     = 900;
    localparam int MAX_GAP        = 9;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_AT        = 300;
    localparam int PAUSE_AT       = 600;

    localparam int unsigned MAIN_MASK = (1 << MAIN_W) - 1;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;
    localparam logic DIR_TO_LOCAL = 1'b0;
    localparam logic DIR_TO_MAIN  = 1'b1;

    // One result as the m_ channel presents it.
    typedef struct packed {
        kind_t                   kind;
        logic                    to_main;
        logic [LOCAL_ADDR_W-1:0] local_byte;
        logic [MAIN_W-1:0]       main_byte;
        logic                    last;
    } dma_result_t;

    // One row of the directed table; fixed rows carry a hand-typed result.
    typedef struct packed {
        logic                    mode;
        logic                    to_main;
        logic [MAIN_IN_W-1:0]    main_in;
        logic [LOCAL_ADDR_W-1:0] local_in;
        logic [LENGTH_W-1:0]     length_word;
        bit                      fixed;
        dma_result_t             result;
    } stim_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_mode;
    logic                    s_to_main;
    logic [MAIN_IN_W-1:0]    s_main_address;
    logic [LOCAL_ADDR_W-1:0] s_local_address;
    logic [LENGTH_W-1:0]     s_length_word;
    logic                    m_valid;
    logic                    m_ready;
    logic [KIND_W-1:0]       m_kind;
    logic                    m_to_main_out;
    logic [LOCAL_ADDR_W-1:0] m_local_byte_address;
    logic [MAIN_W-1:0]       m_main_byte_address;
    logic                    m_last;

    // Predicted copy state.
    bit          walk_active;
    logic        walk_dir;
    int unsigned walk_row_len;
    int unsigned walk_row_skip;
    int unsigned walk_rows_left;
    int unsigned walk_byte_idx;
    int unsigned walk_local_row;
    int unsigned walk_main_row;

    dma_result_t pending_dma_results[$];
    stim_row_t   directed_rows[$];
    int unsigned error_count;
    int unsigned requests_sent;
    int unsigned stuck_cycles;
    bit          sender_no_gaps;
    bit          receiver_no_stall;
    bit          hold_requested;

    strided_dma_address_generator_unit #(
        .LOCAL_SPAN  (LOCAL_SPAN),
        .SEGMENT_SIZE(SEGMENT_SIZE)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_to_main           (s_to_main),
        .s_main_address      (s_main_address),
        .s_local_address     (s_local_address),
        .s_length_word       (s_length_word),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_to_main_out       (m_to_main_out),
        .m_local_byte_address(m_local_byte_address),
        .m_main_byte_address (m_main_byte_address),
        .m_last              (m_last)
    );

    always #CLK_HALF aclk = ~aclk;

    // Computes the result of one request and advances the predicted copy state.
    function automatic dma_result_t predict_dma_step(input logic mode, input logic to_main,
            input logic [MAIN_IN_W-1:0] main_in, input logic [LOCAL_ADDR_W-1:0] local_in,
            input logic [LENGTH_W-1:0] length_word);
        dma_result_t r;
        int unsigned main_m;
        int unsigned field;
        int unsigned loc_b;
        int unsigned main_b;
        r = '0;
        if (mode == MODE_START) begin
            main_m = main_in & MAIN_MASK;
            field  = 32'(length_word[LEN_FIELD_W-1:0]);
            if (main_m > MAIN_LIMIT) begin
                r.kind = KIND_BAD_MAIN;
            end else if (field + 1 + (local_in % SEGMENT_SIZE) > SEGMENT_SIZE) begin
                // The segment test sees the local address before word alignment.
                r.kind = KIND_SEGMENT;
            end else begin
                walk_active    = 1'b1;
                walk_dir       = to_main;
                walk_row_len   = (field | WORD_MASK) + 1;
                walk_row_skip  = 32'(length_word[LENGTH_W-1:SKIP_LSB]) + walk_row_len;
                walk_rows_left = 32'(length_word[SKIP_LSB-1:ROWS_LSB]);
                walk_byte_idx  = 0;
                walk_local_row = (local_in % LOCAL_SPAN) & ~32'(WORD_MASK);
                walk_main_row  = main_m & ~32'(WORD_MASK);
                r.kind = KIND_STARTED;
            end
        end else if (!walk_active) begin
            r.kind = KIND_IDLE;
        end else begin
            loc_b  = ((walk_local_row + walk_byte_idx) % LOCAL_SPAN) ^ LANE_SWAP;
            main_b = ((walk_main_row + walk_byte_idx) & MAIN_MASK) ^ LANE_SWAP;
            r.kind       = KIND_BYTE;
            r.to_main    = walk_dir;
            r.local_byte = loc_b[LOCAL_ADDR_W-1:0];
            r.main_byte  = main_b[MAIN_W-1:0];
            walk_byte_idx++;
            // End of a row: local rows pack back to back, main rows step by the skip.
            if (walk_byte_idx >= walk_row_len) begin
                walk_byte_idx  = 0;
                walk_local_row = (walk_local_row + walk_row_len) % LOCAL_SPAN;
                walk_main_row  = (walk_main_row + walk_row_skip) & MAIN_MASK;
                if (walk_rows_left == 0) begin
                    r.last      = 1'b1;
                    walk_active = 1'b0;
                end else begin
                    walk_rows_left--;
                end
            end
        end
        return r;
    endfunction

    function automatic stim_row_t make_row(input logic mode, input logic to_main,
            input logic [MAIN_IN_W-1:0] main_in, input logic [LOCAL_ADDR_W-1:0] local_in,
            input logic [LENGTH_W-1:0] length_word);
        stim_row_t row;
        row             = '0;
        row.mode        = mode;
        row.to_main     = to_main;
        row.main_in     = main_in;
        row.local_in    = local_in;
        row.length_word = length_word;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input stim_row_t row, input kind_t kind,
            input logic dir, input logic [LOCAL_ADDR_W-1:0] local_byte,
            input logic [MAIN_W-1:0] main_byte, input logic last);
        stim_row_t t;
        t                   = row;
        t.fixed             = 1'b1;
        t.result.kind       = kind;
        t.result.to_main    = dir;
        t.result.local_byte = local_byte;
        t.result.main_byte  = main_byte;
        t.result.last       = last;
        return t;
    endfunction

    // Offers one request, waits for it to be taken and records its result.
    task automatic send_request(input stim_row_t row);
        int unsigned gap;
        dma_result_t predicted;
        gap = sender_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= row.mode;
        s_to_main       <= row.to_main;
        s_main_address  <= row.main_in;
        s_local_address <= row.local_in;
        s_length_word   <= row.length_word;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_dma_step(row.mode, row.to_main, row.main_in, row.local_in,
                                     row.length_word);
        pending_dma_results.push_back(row.fixed ? row.result : predicted);
        requests_sent++;
    endtask

    function automatic stim_row_t random_advance();
        return make_row(MODE_ADVANCE, 1'($urandom), $urandom, 13'($urandom), $urandom);
    endfunction

    // Main address whose low 24 bits pass the limit check; upper byte is random.
    function automatic logic [MAIN_IN_W-1:0] good_main();
        logic [MAIN_IN_W-1:0] a;
        a = $urandom_range(0, 15) == 0 ? MAIN_LIMIT : $urandom_range(0, MAIN_LIMIT);
        a[MAIN_IN_W-1:MAIN_W] = 8'($urandom);
        return a;
    endfunction

    // Stimulus: directed table, then random copies with noise and broken starts.
    initial begin
        stim_row_t   row;
        int unsigned field;
        int unsigned rows_m1;
        int unsigned offset;
        int unsigned copy_bytes;
        int unsigned advances;
        int unsigned pick;
        bit          hold_done;
        bit          pause_done;
        logic [LENGTH_W-1:0] len;

        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_START;
        s_to_main       <= DIR_TO_LOCAL;
        s_main_address  <= '0;
        s_local_address <= '0;
        s_length_word   <= '0;
        error_count     = 0;
        requests_sent   = 0;
        hold_done       = 1'b0;
        pause_done      = 1'b0;
        hold_requested  = 1'b0;
        sender_no_gaps  = 1'b0;

        // Advance while idle right after reset.
        directed_rows.push_back(typed_row(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0),
                                          KIND_IDLE, 1'b0, '0, '0, 1'b0));
        // Bad main addresses: just above the limit and all ones.
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_MAIN, 32'hFF80_0001,
                                                   '0, '0), KIND_BAD_MAIN, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_MAIN, 32'hFFFF_FFFF,
                                                   13'h1FFF, 32'hFFFF_FFFF),
                                          KIND_BAD_MAIN, 1'b0, '0, '0, 1'b0));
        // Start exactly at the main limit: one row of eight bytes.
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_MAIN, 32'h0080_0000,
                                                   '0, '0), KIND_STARTED, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(typed_row(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0),
                                          KIND_BYTE, DIR_TO_MAIN, 13'h0003, 24'h80_0003, 1'b0));
        for (int i = 0; i < 6; i++) begin
            directed_rows.push_back(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0));
        end
        directed_rows.push_back(typed_row(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0),
                                          KIND_BYTE, DIR_TO_MAIN, 13'h0004, 24'h80_0004, 1'b1));
        // Advance after the final byte finds the engine idle again.
        directed_rows.push_back(typed_row(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0),
                                          KIND_IDLE, 1'b0, '0, '0, 1'b0));
        // Row passes the end of its segment by one byte.
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_MAIN, '0, 13'h0FFF,
                                                   32'h0000_0001),
                                          KIND_SEGMENT, 1'b0, '0, '0, 1'b0));
        // Exact segment fit at the top of local memory; the second row wraps to zero.
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_LOCAL, 32'h0000_0007,
                                                   13'h1FFF, 32'hFFF0_1000),
                                          KIND_STARTED, 1'b0, '0, '0, 1'b0));
        for (int i = 0; i < 9; i++) begin
            directed_rows.push_back(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0));
        end
        // Start while busy with the largest length and row count replaces the copy.
        directed_rows.push_back(typed_row(make_row(MODE_START, DIR_TO_MAIN, 32'h1234_5678,
                                                   '0, 32'h000F_FFFF),
                                          KIND_STARTED, 1'b0, '0, '0, 1'b0));
        directed_rows.push_back(make_row(MODE_ADVANCE, DIR_TO_LOCAL, '0, '0, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i]);
        end

        // Random part: mostly complete or cut-short copies, some noise and bad starts.
        while (requests_sent < ITEM_COUNT) begin
            if ($urandom_range(0, 5) == 0) begin
                sender_no_gaps = !sender_no_gaps;
            end
            if (!hold_done && requests_sent >= HOLD_AT) begin
                hold_done      = 1'b1;
                hold_requested = 1'b1;
                sender_no_gaps = 1'b1;
            end
            if (!pause_done && requests_sent >= PAUSE_AT) begin
                pause_done = 1'b1;
                s_valid <= 1'b0;
                while (pending_dma_results.size() != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // Noise: any field value at all.
                send_request(make_row(1'($urandom), 1'($urandom), $urandom, 13'($urandom),
                                      $urandom));
            end else if (pick < 11) begin
                // Main address above the limit.
                row = make_row(MODE_START, 1'($urandom), '0, 13'($urandom), $urandom);
                row.main_in = {8'($urandom), 1'b1, 23'($urandom_range(1, (1 << 23) - 1))};
                send_request(row);
                send_request(random_advance());
            end else if (pick < 14) begin
                // Row that runs past its local segment.
                field  = $urandom_range(1, SEGMENT_SIZE - 1);
                offset = $urandom_range(SEGMENT_SIZE - field, SEGMENT_SIZE - 1);
                len    = $urandom;
                len[LEN_FIELD_W-1:0] = LEN_FIELD_W'(field);
                send_request(make_row(MODE_START, 1'($urandom), good_main(),
                                      {1'($urandom), 12'(offset)}, len));
                send_request(random_advance());
            end else begin
                // Well-formed copy: small ones run to the end, large ones are cut short.
                len = $urandom;
                if ($urandom_range(0, 9) < 7) begin
                    field   = $urandom_range(0, 23);
                    rows_m1 = $urandom_range(0, 3);
                    len[SKIP_LSB-1:ROWS_LSB] = ROWS_W'(rows_m1);
                end else begin
                    field   = $urandom_range(0, SEGMENT_SIZE - 1);
                    rows_m1 = 32'(len[SKIP_LSB-1:ROWS_LSB]);
                end
                len[LEN_FIELD_W-1:0] = LEN_FIELD_W'(field);
                offset     = $urandom_range(0, SEGMENT_SIZE - 1 - field);
                copy_bytes = ((field | WORD_MASK) + 1) * (rows_m1 + 1);
                advances   = copy_bytes <= 96 ? copy_bytes + $urandom_range(0, 2)
                                              : $urandom_range(0, 24);
                send_request(make_row(MODE_START, 1'($urandom), good_main(),
                                      {1'($urandom), 12'(offset)}, len));
                for (int i = 0; i < advances; i++) begin
                    send_request(random_advance());
                end
            end
        end
        s_valid <= 1'b0;

        // Drain: every result must arrive, then the run waits on to watch for strays.
        while (pending_dma_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_dma_results.size() != 0) begin
            $error("%0d results never arrived", pending_dma_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random stalls, stall-free stretches and one long hold-off.
    initial begin
        int unsigned stall;
        dma_result_t exp;
        m_ready           <= 1'b0;
        receiver_no_stall = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                receiver_no_stall = !receiver_no_stall;
            end
            if (hold_requested) begin
                hold_requested = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = receiver_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_dma_results.size() == 0) begin
                $error("result with no pending request: kind %0d", m_kind);
                error_count++;
            end else begin
                exp = pending_dma_results.pop_front();
                if (m_kind !== exp.kind) begin
                    $error("kind: expected %0d, got %0d", exp.kind, m_kind);
                    error_count++;
                end
                if (m_to_main_out !== exp.to_main) begin
                    $error("to_main_out: expected %0d, got %0d", exp.to_main, m_to_main_out);
                    error_count++;
                end
                if (m_local_byte_address !== exp.local_byte) begin
                    $error("local_byte_address: expected 0x%0h, got 0x%0h",
                           exp.local_byte, m_local_byte_address);
                    error_count++;
                end
                if (m_main_byte_address !== exp.main_byte) begin
                    $error("main_byte_address: expected 0x%0h, got 0x%0h",
                           exp.main_byte, m_main_byte_address);
                    error_count++;
                end
                if (m_last !== exp.last) begin
                    $error("last: expected %0d, got %0d", exp.last, m_last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no request or result moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule

// ===== strided_dma_address_generator_unit.f =====
hw/rtl/dsag_pkg.sv
hw/rtl/dsag_front.sv
hw/rtl/dsag_queue.sv
hw/rtl/dsag_back.sv
hw/rtl/strided_dma_address_generator_unit.sv
tb/sv/strided_dma_address_generator_unit_tb.sv
